[hw/rtl/plrd_pkg.sv]
// Shared types and constants of the PackBits run-length decoder.
package plrd_pkg;

    // Depth of the run queue between the header parser and the expander.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Header byte values of note.
    localparam logic [7:0] HDR_NOP      = 8'h80;
    localparam logic [8:0] REPEAT_BASE  = 9'd257;

    // Lane counts of a result.
    localparam logic [1:0] LANES_ONE = 2'd1;
    localparam logic [1:0] LANES_TWO = 2'd2;

    // Parser state, one-hot.
    typedef enum logic [2:0] {
        MODE_HEADER  = 3'b001,
        MODE_LITERAL = 3'b010,
        MODE_REPEAT  = 3'b100
    } t_mode;

    // One queued run: a byte and how many copies of it to give out (1..128).
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] copies;
    } t_run;

    // Handshake between queue and expander.
    typedef struct packed {
        logic head_valid;
        t_run head;
    } t_queue_head;

endpackage

[hw/rtl/plrd_front.sv]
// Header parser: accepts compressed bytes and turns data bytes into queued runs.
module plrd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_last_in,
    input  logic          i_queue_full,
    output logic          o_in_ready,
    output logic          o_push,
    output plrd_pkg::t_run o_push_run
);
    import plrd_pkg::*;

    t_mode      r_mode, n_mode;
    logic [7:0] r_left, n_left;
    logic       accept;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    always_comb begin
        n_mode            = r_mode;
        n_left            = r_left;
        o_push            = 1'b0;
        o_push_run.value  = i_in_byte;
        o_push_run.copies = r_left;
        if (accept) begin
            case (r_mode)
                MODE_LITERAL: begin
                    o_push            = 1'b1;
                    o_push_run.copies = 8'd1;
                    n_left            = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_mode = MODE_HEADER;
                    end
                end
                MODE_REPEAT: begin
                    o_push = 1'b1;
                    n_left = 8'd0;
                    n_mode = MODE_HEADER;
                end
                default: begin
                    if (!i_in_byte[7]) begin
                        n_left = i_in_byte + 8'd1;
                        n_mode = MODE_LITERAL;
                    end else if (i_in_byte == HDR_NOP) begin
                        n_left = 8'd0;
                        n_mode = MODE_HEADER;
                    end else begin
                        n_left = 8'(REPEAT_BASE - {1'b0, i_in_byte});
                        n_mode = MODE_REPEAT;
                    end
                end
            endcase
            if (i_last_in) begin
                n_mode = MODE_HEADER;
                n_left = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEADER;
            r_left <= 8'd0;
        end else begin
            r_mode <= n_mode;
            r_left <= n_left;
        end
    end

endmodule

[hw/rtl/plrd_queue.sv]
// Short register queue of runs between the parser and the expander.
module plrd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  plrd_pkg::t_run        i_push_run,
    input  logic                  i_pop,
    output logic                  o_full,
    output plrd_pkg::t_queue_head o_head
);
    import plrd_pkg::*;

    t_run                r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push, do_pop;

    assign o_full          = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_head.head_valid = (r_count != '0);
    assign o_head.head     = r_entry[r_rd_ptr];
    assign do_push         = i_push && !o_full;
    assign do_pop          = i_pop && o_head.head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/plrd_back.sv]
// Run expander: gives out the copies of each queued run, up to two bytes per result.
module plrd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  plrd_pkg::t_queue_head i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte0,
    output logic [7:0]            o_out_byte1,
    output logic [1:0]            o_lane_count,
    output logic                  o_run_last
);
    import plrd_pkg::*;

    logic [7:0] r_value, r_left, n_left;
    logic       busy, src_valid, load, two;
    logic [7:0] src_value, src_left;
    logic       r_out_valid;
    logic [7:0] r_byte0, r_byte1;
    logic [1:0] r_lanes;
    logic       r_last;

    // Copies still owed from the current run take priority over the queue head.
    assign busy      = (r_left != 8'd0);
    assign src_valid = busy || i_head.head_valid;
    assign src_value = busy ? r_value : i_head.head.value;
    assign src_left  = busy ? r_left : i_head.head.copies;
    assign load      = src_valid && (!r_out_valid || i_out_ready);
    assign o_pop     = load && !busy;
    assign two       = (src_left >= 8'd2);
    assign n_left    = src_left - (two ? 8'd2 : 8'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_left <= n_left;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= src_value;
            r_byte0 <= src_value;
            r_byte1 <= two ? src_value : 8'd0;
            r_lanes <= two ? LANES_TWO : LANES_ONE;
            r_last  <= (n_left == 8'd0);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte0  = r_byte0;
    assign o_out_byte1  = r_byte1;
    assign o_lane_count = r_lanes;
    assign o_run_last   = r_last;

`ifndef NO_ASSERTIONS
    a_lanes_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_lane_count == LANES_ONE || o_lane_count == LANES_TWO))
        else $error("lane count out of range");

    a_single_lane_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_lane_count == LANES_ONE) |-> (o_run_last && o_out_byte1 == 8'd0))
        else $error("single-lane result must close its run with an empty second lane");

    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_pop)
        else $error("queue popped while a run is still being expanded");

    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 8'd126)
        else $error("remaining copy count exceeds the longest run");
`endif

endmodule

[hw/rtl/packbits_run_length_decoder.sv]
// Top level of the PackBits run-length decoder.
//
// The decoder takes one compressed byte per transfer and accepts a new byte in every
// cycle while its four-entry run queue has room, whatever the output side is doing. A
// header byte of 0 to 127 announces that many plus one literal bytes, each of which is
// passed through as one result with a lane count of one; a header of -127 to -1 makes
// the following byte repeat 1-header times, and those copies come out two per result
// with the final result of the run flagged by run_last (an odd count ends on a single
// lane with the second byte zero). A header of -128 is a no-op. A byte marked last
// returns the parser to header mode once it has been handled; a run cut short this way
// is dropped silently. Header bytes produce no result. A data byte passes a queue entry
// and then the output register; thereafter the expander gives one result per cycle while
// the consumer takes them, so a literal fills one result and a repeat run of n copies
// fills ceil(n/2) results of the output register, which sets the sustained rate. Input
// stalls only when the queue fills behind a long repeat run or a stalled consumer.
module packbits_run_length_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte0,
    output logic [7:0] o_out_byte1,
    output logic [1:0] o_lane_count,
    output logic       o_run_last
);
    import plrd_pkg::*;

    logic        push, pop, queue_full;
    t_run        push_run;
    t_queue_head head;

    // The parser tracks header, literal and repeat modes and pushes one run per data byte.
    plrd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_byte    (i_in_byte),
        .i_last_in    (i_last_in),
        .i_queue_full (queue_full),
        .o_in_ready   (o_in_ready),
        .o_push       (push),
        .o_push_run   (push_run)
    );

    // The queue decouples the parser from the expander so that each may stall alone.
    plrd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_run (push_run),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_head     (head)
    );

    // The expander drains runs into the registered output, up to two copies per result.
    plrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte0  (o_out_byte0),
        .o_out_byte1  (o_out_byte1),
        .o_lane_count (o_lane_count),
        .o_run_last   (o_run_last)
    );

endmodule
